// File: rtl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// Full checks in simulation; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define TTOK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A condition that must never be true at a clock edge outside reset.
`define TTOK_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TTOK_ASSERT(label, clk, rst_n, prop, msg)
`define TTOK_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/ttok_pkg.sv
// Package for the text word tokenizer: widths, character codes and the
// byte classification functions. Depends on nothing.
`timescale 1ns / 1ps

package ttok_pkg;

    localparam int CHAR_W             = 8;
    localparam int CHAR_IDX_W         = 6;
    localparam int WORD_IDX_W         = 16;
    localparam int DEF_MAX_WORD_LEN   = 64;
    localparam int DEF_MAX_TEXT_BYTES = 65536;
    localparam int MIN_WORD_LEN       = 2;

    // Two word banks: one fills while the other drains.
    localparam int NUM_BANKS   = 2;
    localparam int BANK_W      = 1;
    localparam int QUEUE_DEPTH = NUM_BANKS;

    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] UPPER_A     = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;
    localparam logic [CHAR_W-1:0] DIGIT_0     = 8'h30;
    localparam logic [CHAR_W-1:0] DIGIT_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    localparam logic [WORD_IDX_W-1:0] WORD_IDX_MAX = '1;

    // Hand-back of a bank once its last character has been read.
    typedef struct packed {
        logic              valid;
        logic [BANK_W-1:0] bank;
    } bank_rel_t;

    // Space, tab, line feed, vertical tab, form feed and carriage return.
    function automatic logic is_space(input logic [CHAR_W-1:0] b);
        return b inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
    endfunction

    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] b);
        return (b inside {[UPPER_A:UPPER_Z]}) ? b + CASE_OFFSET : b;
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return c inside {[LOWER_A:LOWER_Z]};
    endfunction

    function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
        return is_alpha(c) || (c inside {[DIGIT_0:DIGIT_9], CHAR_SLASH});
    endfunction

endpackage

// File: rtl/ttok_front.sv
// Front end of the tokenizer: takes text bytes, classifies them, writes
// word characters into the bank store and queues finished words.
// Depends on ttok_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttok_front #(
    parameter int  MAX_WORD_LEN   = ttok_pkg::DEF_MAX_WORD_LEN,
    parameter int  MAX_TEXT_BYTES = ttok_pkg::DEF_MAX_TEXT_BYTES,
    parameter type desc_t         = logic,
    parameter type store_wr_t     = logic
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ttok_pkg::CHAR_W-1:0]  text_byte,
    input  logic                         end_of_text,
    output logic                         push_valid,
    output desc_t                        push_desc,
    output store_wr_t                    store_wr,
    input  ttok_pkg::bank_rel_t          bank_rel
);
    import ttok_pkg::*;

    localparam int CNT_W = $clog2(MAX_WORD_LEN + 1);
    localparam int IDX_W = $clog2(MAX_WORD_LEN);
    localparam int OFF_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_WORD_LEN);
    localparam logic [CNT_W-1:0] MIN_LEN = CNT_W'(MIN_WORD_LEN);
    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_TEXT_BYTES);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  letter_reg, letter_next;
    logic                  hyph_reg, hyph_next;
    logic [OFF_W-1:0]      pos_reg, pos_next;
    logic [OFF_W-1:0]      start_reg, start_next;
    logic [WORD_IDX_W-1:0] wcount_reg, wcount_next;
    logic [BANK_W-1:0]     bank_reg, bank_next;
    logic [NUM_BANKS-1:0]  busy_reg, busy_next;

    logic                  accept;
    logic [CHAR_W-1:0]     lc;
    logic [OFF_W-1:0]      pos_inc;
    logic                  close;
    logic [OFF_W-1:0]      close_off;
    logic [CNT_W-1:0]      close_len;
    logic                  close_letter;

    // A byte is taken only while the bank being filled is free.
    assign in_ready = !busy_reg[bank_reg];
    assign accept   = in_valid && in_ready;
    assign lc       = to_lower(text_byte);
    assign pos_inc  = (pos_reg == OFF_MAX) ? OFF_MAX : pos_reg + 1'b1;

    // Byte classification and word building.
    always_comb
    begin
        cnt_next     = cnt_reg;
        letter_next  = letter_reg;
        hyph_next    = hyph_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        wcount_next  = wcount_reg;
        bank_next    = bank_reg;
        busy_next    = busy_reg;
        close        = 1'b0;
        close_off    = pos_reg;
        close_len    = '0;
        close_letter = 1'b0;
        store_wr.en   = 1'b0;
        store_wr.addr = {bank_reg, cnt_reg[IDX_W-1:0]};
        store_wr.data = lc;
        push_valid   = 1'b0;

        if (accept)
        begin
            // Whitespace after a dropped hyphen is swallowed.
            if (!(hyph_reg && is_space(text_byte)))
            begin
                hyph_next = 1'b0;
                if (cnt_reg != '0 && text_byte == CHAR_HYPHEN)
                begin
                    hyph_next = 1'b1;
                end
                else if (is_word_char(lc))
                begin
                    if (cnt_reg == '0)
                    begin
                        start_next  = pos_reg;
                        letter_next = 1'b0;
                    end
                    if (cnt_reg < LEN_MAX)
                    begin
                        store_wr.en = 1'b1;
                        if (is_alpha(lc))
                        begin
                            letter_next = 1'b1;
                        end
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if (cnt_reg != '0)
                begin
                    close = 1'b1;
                end
            end
            pos_next = pos_inc;
            // At end of text a word still open after this byte closes one past it.
            if (end_of_text && !close && cnt_next != '0)
            begin
                close     = 1'b1;
                close_off = pos_inc;
            end
        end

        close_len    = cnt_next;
        close_letter = letter_next;

        if (close)
        begin
            if (close_len >= MIN_LEN && close_letter)
            begin
                push_valid          = 1'b1;
                busy_next[bank_reg] = 1'b1;
                bank_next           = bank_reg + BANK_W'(1);
                wcount_next = (wcount_reg == WORD_IDX_MAX) ? wcount_reg
                                                           : wcount_reg + 1'b1;
            end
            cnt_next    = '0;
            letter_next = 1'b0;
        end

        if (accept && end_of_text)
        begin
            cnt_next    = '0;
            letter_next = 1'b0;
            hyph_next   = 1'b0;
            pos_next    = '0;
            wcount_next = '0;
        end

        if (bank_rel.valid)
        begin
            busy_next[bank_rel.bank] = 1'b0;
        end
    end

    // Descriptor of the word being handed to the back end.
    always_comb
    begin
        push_desc           = '0;
        push_desc.bank      = bank_reg;
        push_desc.len       = close_len;
        push_desc.word_idx  = wcount_reg;
        push_desc.start_off = start_next;
        push_desc.end_off   = close_off;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            letter_reg <= 1'b0;
            hyph_reg   <= 1'b0;
            pos_reg    <= '0;
            start_reg  <= '0;
            wcount_reg <= '0;
            bank_reg   <= '0;
            busy_reg   <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            letter_reg <= letter_next;
            hyph_reg   <= hyph_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            wcount_reg <= wcount_next;
            bank_reg   <= bank_next;
            busy_reg   <= busy_next;
        end
    end

    // Checks on bank ownership and the word counters.
    `TTOK_ASSERT(a_rel_held, clk, rst_n, bank_rel.valid |-> busy_reg[bank_rel.bank], "bank released while not held")
    `TTOK_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= LEN_MAX, "character count beyond word limit")
    `TTOK_ASSERT(a_eot_clear, clk, rst_n, accept && end_of_text |=> cnt_reg == '0 && pos_reg == '0, "end of text did not clear state")

endmodule

// File: rtl/ttok_queue.sv
// Short descriptor queue between the tokenizer front and back ends.
// Depends on ttok_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttok_queue #(
    parameter type desc_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  desc_t push_desc,
    input  logic  pop,
    output logic  q_valid,
    output desc_t q_desc
);
    import ttok_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    desc_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_valid = count_reg != '0;
    assign q_desc  = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_valid && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push_valid)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // The bank scheme must keep the queue from overflowing.
    `TTOK_ASSERT_NEVER(a_q_overflow, clk, rst_n, push_valid && count_reg == FULL_CNT && !pop, "push into full queue")
    `TTOK_ASSERT_NEVER(a_q_underflow, clk, rst_n, pop && count_reg == '0, "pop from empty queue")
    `TTOK_ASSERT(a_q_count, clk, rst_n, count_reg <= FULL_CNT, "queue count out of range")

endmodule

// File: rtl/ttok_back.sv
// Back end of the tokenizer: holds the two-bank word store and streams
// each queued word out one character per result through a read stage.
// Depends on ttok_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttok_back #(
    parameter int  MAX_WORD_LEN   = ttok_pkg::DEF_MAX_WORD_LEN,
    parameter int  MAX_TEXT_BYTES = ttok_pkg::DEF_MAX_TEXT_BYTES,
    parameter type desc_t         = logic,
    parameter type store_wr_t     = logic
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  desc_t                             q_desc,
    output logic                              q_pop,
    input  store_wr_t                         store_wr,
    output ttok_pkg::bank_rel_t               bank_rel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ttok_pkg::CHAR_W-1:0]       word_char,
    output logic [ttok_pkg::CHAR_IDX_W-1:0]   char_index,
    output logic                              word_last,
    output logic [ttok_pkg::WORD_IDX_W-1:0]   word_index,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] start_offset,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] end_offset
);
    import ttok_pkg::*;

    localparam int CNT_W     = $clog2(MAX_WORD_LEN + 1);
    localparam int IDX_W     = $clog2(MAX_WORD_LEN);
    localparam int OFF_W     = $clog2(MAX_TEXT_BYTES + 1);
    localparam int ADDR_W    = BANK_W + IDX_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    logic [CHAR_W-1:0]     mem [MEM_DEPTH];

    logic                  act_reg;
    desc_t                 desc_reg;
    logic [CNT_W-1:0]      k_reg;

    logic                  s1_valid_reg;
    logic [CHAR_W-1:0]     mem_q_reg;
    logic [CHAR_IDX_W-1:0] s1_idx_reg;
    logic                  s1_last_reg;
    logic [WORD_IDX_W-1:0] s1_widx_reg;
    logic [OFF_W-1:0]      s1_start_reg;
    logic [OFF_W-1:0]      s1_end_reg;

    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic [CHAR_IDX_W-1:0] out_idx_reg;
    logic                  out_last_reg;
    logic [WORD_IDX_W-1:0] out_widx_reg;
    logic [OFF_W-1:0]      out_start_reg;
    logic [OFF_W-1:0]      out_end_reg;

    logic                  s1_move;
    logic                  rd_en;
    logic                  rd_last;
    logic [ADDR_W-1:0]     rd_addr;

    // A read is issued only when the read stage is empty or passes its data on in this cycle.
    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign rd_en   = act_reg && (!s1_valid_reg || s1_move);
    assign rd_last = (k_reg + 1'b1) == desc_reg.len;
    assign rd_addr = {desc_reg.bank, k_reg[IDX_W-1:0]};
    assign q_pop   = q_valid && !act_reg;

    // The bank goes back to the front once its last character is read.
    assign bank_rel.valid = rd_en && rd_last;
    assign bank_rel.bank  = desc_reg.bank;

    // Word store: one write port from the front, one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            mem[store_wr.addr] <= store_wr.data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Word sequencer and valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                act_reg <= 1'b1;
                k_reg   <= '0;
            end
            else if (rd_en)
            begin
                if (rd_last)
                begin
                    act_reg <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end

            if (rd_en)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the descriptor, the read stage and the output register.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            desc_reg <= q_desc;
        end
        if (rd_en)
        begin
            s1_idx_reg   <= CHAR_IDX_W'(k_reg);
            s1_last_reg  <= rd_last;
            s1_widx_reg  <= desc_reg.word_idx;
            s1_start_reg <= desc_reg.start_off;
            s1_end_reg   <= desc_reg.end_off;
        end
        if (s1_move)
        begin
            out_char_reg  <= mem_q_reg;
            out_idx_reg   <= s1_idx_reg;
            out_last_reg  <= s1_last_reg;
            out_widx_reg  <= s1_widx_reg;
            out_start_reg <= s1_start_reg;
            out_end_reg   <= s1_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign word_char    = out_char_reg;
    assign char_index   = out_idx_reg;
    assign word_last    = out_last_reg;
    assign word_index   = out_widx_reg;
    assign start_offset = out_start_reg;
    assign end_offset   = out_end_reg;

    // Sequencer checks.
    `TTOK_ASSERT(a_k_range, clk, rst_n, act_reg |-> k_reg < desc_reg.len, "character index past word length")
    `TTOK_ASSERT(a_last_done, clk, rst_n, rd_en && rd_last |=> !act_reg, "sequencer busy after last character")
    `TTOK_ASSERT(a_pop_start, clk, rst_n, q_pop |=> act_reg && k_reg == '0, "word did not start at first character")

endmodule

// File: rtl/text_word_tokenizer_unit.sv
// Top level of the text word tokenizer: front end, descriptor queue and
// back end with its two-bank word store. Depends on all files above.
`timescale 1ns / 1ps

// The unit takes one text byte per cycle on the input channel while
// in_ready is high, and emits each accepted word as one result per
// character, one per cycle while the output is not stalled, with its
// index, last mark and byte offsets. A word's characters are held in
// one of two banks: the front fills one bank while the back end reads the
// other out, so a byte is accepted every cycle unless both banks hold
// finished words; the input then waits until the back end has read the
// last character of the older word. After the closing byte is accepted,
// the word's descriptor passes through the queue and the sequencer, and
// its characters through the read stage and the output register. The back
// end pops the next descriptor only once it has read the last character
// of the current word. The store needs no clearing after reset.
module text_word_tokenizer_unit #(
    parameter int MAX_WORD_LEN   = ttok_pkg::DEF_MAX_WORD_LEN,
    parameter int MAX_TEXT_BYTES = ttok_pkg::DEF_MAX_TEXT_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ttok_pkg::CHAR_W-1:0]         text_byte,
    input  logic                                end_of_text,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ttok_pkg::CHAR_W-1:0]         word_char,
    output logic [ttok_pkg::CHAR_IDX_W-1:0]     char_index,
    output logic                                word_last,
    output logic [ttok_pkg::WORD_IDX_W-1:0]     word_index,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] start_offset,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] end_offset
);
    import ttok_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int IDX_W  = $clog2(MAX_WORD_LEN);
    localparam int OFF_W  = $clog2(MAX_TEXT_BYTES + 1);
    localparam int ADDR_W = BANK_W + IDX_W;

    // Finished word as it travels from front to back.
    typedef struct packed {
        logic [BANK_W-1:0]     bank;
        logic [CNT_W-1:0]      len;
        logic [WORD_IDX_W-1:0] word_idx;
        logic [OFF_W-1:0]      start_off;
        logic [OFF_W-1:0]      end_off;
    } desc_t;

    // Character write into the word store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } store_wr_t;

    logic      push_valid;
    desc_t     push_desc;
    logic      q_valid;
    desc_t     q_desc;
    logic      q_pop;
    store_wr_t store_wr;
    bank_rel_t bank_rel;

    // Byte classification and word building.
    ttok_front #(
        .MAX_WORD_LEN  (MAX_WORD_LEN),
        .MAX_TEXT_BYTES(MAX_TEXT_BYTES),
        .desc_t        (desc_t),
        .store_wr_t    (store_wr_t)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .end_of_text(end_of_text),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .store_wr   (store_wr),
        .bank_rel   (bank_rel)
    );

    // Finished words waiting for the back end.
    ttok_queue #(
        .desc_t(desc_t)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_desc (push_desc),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_desc    (q_desc)
    );

    // Character emission.
    ttok_back #(
        .MAX_WORD_LEN  (MAX_WORD_LEN),
        .MAX_TEXT_BYTES(MAX_TEXT_BYTES),
        .desc_t        (desc_t),
        .store_wr_t    (store_wr_t)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_desc      (q_desc),
        .q_pop       (q_pop),
        .store_wr    (store_wr),
        .bank_rel    (bank_rel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .word_char   (word_char),
        .char_index  (char_index),
        .word_last   (word_last),
        .word_index  (word_index),
        .start_offset(start_offset),
        .end_offset  (end_offset)
    );

endmodule
